[design/bfa_pkg.sv]
package bfa_pkg;

    // Map geometry and address mapping
    localparam int FRAMES      = 65536;
    localparam int PAGE_SHIFT  = 12;
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = 5;
    localparam int MAP_WORDS   = FRAMES / WORD_BITS;
    localparam int WORD_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FRAME_W     = WORD_W + BIT_W;
    localparam int ADDR_W      = 32;
    localparam int SFRAME_W    = ADDR_W - PAGE_SHIFT;

    // Limit register and frame counter
    localparam int LIM_W       = 17;
    localparam int COUNT_MAX   = (2 ** LIM_W) - 1;
    localparam int LIMIT_RESET = 65536;
    localparam int USED_RESET  = (LIMIT_RESET > FRAMES) ? FRAMES : LIMIT_RESET;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2,
        OP_INIT    = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [ADDR_W-1:0]   address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   frame_address;
        logic                found;
        logic [LIM_W-1:0]    used_count;
        logic [LIM_W-1:0]    free_count;
    } rsp_t;

    // Command from the sequencer to the shared word unit
    typedef struct packed {
        logic [BIT_W-1:0]    bit_sel;
        logic                set_bit;
        logic [LIM_W-1:0]    span;
    } word_cmd_t;

    // Results of the shared word unit
    typedef struct packed {
        logic [WORD_BITS-1:0] alloc_word;
        logic                 alloc_hit;
        logic [BIT_W-1:0]     alloc_bit;
        logic [WORD_BITS-1:0] mod_word;
        logic                 old_bit;
    } word_res_t;

endpackage

[design/bitmap_frame_allocator_unit.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  bfa_pkg::req_t (opcode, address)
// rsp       out        rsp_valid / rsp_stall  bfa_pkg::rsp_t (address, found, counts)
// cfg       in         cfg_valid / cfg_ready  cfg_data, frame_limit (17 bits)
//
// Free and reserve act on one bitmap word, init refills the bitmap with ones,
// and allocate reads and checks one word at a time, stopping at a free frame,
// at the frame total or after the last word, paced by the single read port of the
// bitmap memory and the shared word unit that checks one word per pass.
// After reset a clearing pass fills the bitmap with ones; requests are stalled
// meanwhile, configuration writes are always taken.
// A request may be accepted while the previous response still waits in the output
// register; a stalled response holds the sequencer in its response state.
module bitmap_frame_allocator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  bfa_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output bfa_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bfa_pkg::LIM_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_MOD_RD,
        ST_MOD_EV,
        ST_RESP
    } state_t;

    localparam logic [bfa_pkg::WORD_W-1:0] LAST_WORD =
        bfa_pkg::WORD_W'(bfa_pkg::MAP_WORDS - 1);

    state_t                            state_reg, state_next;
    logic [bfa_pkg::WORD_W-1:0]        word_reg, word_next;
    bfa_pkg::opcode_t                  op_reg, op_next;
    logic [bfa_pkg::SFRAME_W-1:0]      frame_reg, frame_next;
    logic                              init_reg, init_next;
    logic                              found_reg, found_next;
    logic [bfa_pkg::ADDR_W-1:0]        faddr_reg, faddr_next;
    logic [bfa_pkg::LIM_W-1:0]         used_reg, used_next;
    logic [bfa_pkg::LIM_W-1:0]         limit_reg;
    logic                              rsp_valid_reg, rsp_valid_next;
    bfa_pkg::rsp_t                     rsp_reg, rsp_next;

    logic [bfa_pkg::LIM_W-1:0]         lim;
    logic [bfa_pkg::ADDR_W-1:0]        base;
    logic [bfa_pkg::ADDR_W-1:0]        req_frame;
    logic                              ram_we;
    logic [bfa_pkg::WORD_W-1:0]        ram_waddr;
    logic [bfa_pkg::WORD_BITS-1:0]     ram_wdata;
    logic [bfa_pkg::WORD_BITS-1:0]     ram_rdata;
    bfa_pkg::word_cmd_t                cmd;
    bfa_pkg::word_res_t                res;

    // Effective frame total is the limit clamped to the map size.
    assign lim = (32'(limit_reg) > 32'(bfa_pkg::FRAMES))
                 ? bfa_pkg::LIM_W'(bfa_pkg::FRAMES) : limit_reg;
    assign base      = bfa_pkg::ADDR_W'({word_reg, bfa_pkg::BIT_W'(0)});
    assign req_frame = req.address >> bfa_pkg::PAGE_SHIFT;

    // Command for the shared word unit.
    assign cmd.bit_sel = frame_reg[bfa_pkg::BIT_W-1:0];
    assign cmd.set_bit = (op_reg == bfa_pkg::OP_RESERVE);
    assign cmd.span    = bfa_pkg::LIM_W'(32'(lim) - base);

    bfa_map_ram u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (word_reg),
        .rdata (ram_rdata)
    );

    bfa_word_unit u_word (
        .data (ram_rdata),
        .cmd  (cmd),
        .res  (res)
    );

    // Sequencer next-state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        op_next        = op_reg;
        frame_next     = frame_reg;
        init_next      = init_reg;
        found_next     = found_reg;
        faddr_next     = faddr_reg;
        used_next      = used_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = word_reg;
        ram_wdata      = '1;

        // The output register empties when its response is taken.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '1;
                if (word_reg == LAST_WORD)
                begin
                    word_next = '0;
                    if (init_reg)
                    begin
                        init_next  = 1'b0;
                        used_next  = lim;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    word_next = word_reg + bfa_pkg::WORD_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.opcode;
                    frame_next = bfa_pkg::SFRAME_W'(req_frame);
                    found_next = 1'b0;
                    faddr_next = '0;
                    case (req.opcode)
                        bfa_pkg::OP_ALLOC:
                        begin
                            word_next  = '0;
                            state_next = ST_SCAN_RD;
                        end
                        bfa_pkg::OP_FREE, bfa_pkg::OP_RESERVE:
                        begin
                            word_next  = bfa_pkg::WORD_W'(req_frame >> bfa_pkg::BIT_W);
                            state_next = ST_MOD_RD;
                        end
                        default:
                        begin
                            word_next  = '0;
                            init_next  = 1'b1;
                            state_next = ST_CLEAR;
                        end
                    endcase
                end
            end

            // The read of the current word is under way; stop at the limit.
            ST_SCAN_RD:
            begin
                if (base >= 32'(lim))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_SCAN_EV;
                end
            end

            ST_SCAN_EV:
            begin
                if (res.alloc_hit)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = res.alloc_word;
                    found_next = 1'b1;
                    faddr_next = bfa_pkg::ADDR_W'({word_reg, res.alloc_bit})
                                 << bfa_pkg::PAGE_SHIFT;
                    if (32'(used_reg) < 32'(bfa_pkg::COUNT_MAX))
                    begin
                        used_next = used_reg + bfa_pkg::LIM_W'(1);
                    end
                    state_next = ST_RESP;
                end
                else if (word_reg == LAST_WORD)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    word_next  = word_reg + bfa_pkg::WORD_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            // Frames at or beyond the total are left alone.
            ST_MOD_RD:
            begin
                if (32'(frame_reg) >= 32'(lim))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_MOD_EV;
                end
            end

            // Only a bit that actually changes moves the count.
            ST_MOD_EV:
            begin
                if (res.old_bit != cmd.set_bit)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = res.mod_word;
                    if (cmd.set_bit)
                    begin
                        if (32'(used_reg) < 32'(bfa_pkg::COUNT_MAX))
                        begin
                            used_next = used_reg + bfa_pkg::LIM_W'(1);
                        end
                    end
                    else if (used_reg != '0)
                    begin
                        used_next = used_reg - bfa_pkg::LIM_W'(1);
                    end
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.frame_address = faddr_reg;
                    rsp_next.found         = found_reg;
                    rsp_next.used_count    = used_reg;
                    rsp_next.free_count    = (lim > used_reg) ? (lim - used_reg) : '0;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, control and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            word_reg      <= '0;
            init_reg      <= 1'b0;
            used_reg      <= bfa_pkg::LIM_W'(bfa_pkg::USED_RESET);
            limit_reg     <= bfa_pkg::LIM_W'(bfa_pkg::LIMIT_RESET);
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            init_reg      <= init_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        frame_reg <= frame_next;
        found_reg <= found_next;
        faddr_reg <= faddr_next;
        rsp_reg   <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

endmodule

[design/bfa_map_ram.sv]
module bfa_map_ram (
    input  logic                              clk,
    input  logic                              we,
    input  logic [bfa_pkg::WORD_W-1:0]        waddr,
    input  logic [bfa_pkg::WORD_BITS-1:0]     wdata,
    input  logic [bfa_pkg::WORD_W-1:0]        raddr,
    output logic [bfa_pkg::WORD_BITS-1:0]     rdata
);

    logic [bfa_pkg::WORD_BITS-1:0] mem [bfa_pkg::MAP_WORDS];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/bfa_word_unit.sv]
module bfa_word_unit (
    input  logic [bfa_pkg::WORD_BITS-1:0] data,
    input  bfa_pkg::word_cmd_t            cmd,
    output bfa_pkg::word_res_t            res
);

    logic [bfa_pkg::WORD_BITS-1:0] avail;
    logic [bfa_pkg::WORD_BITS-1:0] first_mask;
    logic [bfa_pkg::WORD_BITS-1:0] sel_mask;
    logic [bfa_pkg::BIT_W-1:0]     first_bit;

    // Free bits of the word, trimmed to the frames below the limit.
    always_comb
    begin
        avail = ~data;
        if (cmd.span < bfa_pkg::LIM_W'(bfa_pkg::WORD_BITS))
        begin
            avail = avail & ((bfa_pkg::WORD_BITS'(1) << cmd.span[bfa_pkg::BIT_W-1:0])
                             - bfa_pkg::WORD_BITS'(1));
        end
    end

    // Priority encoder for the lowest free bit.
    always_comb
    begin
        first_bit = '0;
        for (int i = bfa_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                first_bit = bfa_pkg::BIT_W'(i);
            end
        end
    end

    assign first_mask = bfa_pkg::WORD_BITS'(1) << first_bit;
    assign sel_mask   = bfa_pkg::WORD_BITS'(1) << cmd.bit_sel;

    // Updated words for allocate and for a single-bit set or clear.
    always_comb
    begin
        res.alloc_hit  = |avail;
        res.alloc_bit  = first_bit;
        res.alloc_word = data | first_mask;
        res.old_bit    = data[cmd.bit_sel];
        res.mod_word   = cmd.set_bit ? (data | sel_mask) : (data & ~sel_mask);
    end

endmodule

[design/bfa_checker.sv]
module bfa_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  bfa_pkg::req_t                 req,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  bfa_pkg::rsp_t                 rsp
);

    // A stalled response stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // A response without a found frame carries a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.frame_address == '0)
        else $error("address reported without a found frame");

    // Used plus free never exceeds the map size when frames are free.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.free_count != '0
        |-> 32'(rsp.used_count) + 32'(rsp.free_count) <= 32'(bfa_pkg::FRAMES))
        else $error("frame counts exceed the map size");

    // The clearing pass holds off requests right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> req_stall)
        else $error("request taken during the clearing pass");

    // An accepted init request keeps the block busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.opcode == bfa_pkg::OP_INIT |=> req_stall)
        else $error("init request finished without a fill");

endmodule

bind bitmap_frame_allocator_unit bfa_checker u_bfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
